>>> rtl/core/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants for the variable-length code packer
// Request kinds, table entry layout, code length limit and load clamping.
// ----------------------------------------------------------------------------
package hte_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FINISH = 2'd2
  } req_type_t;

  // longest code the packer accepts, and the effective limit of the table
  localparam int          MAX_CODE_LEN   = 32;
  localparam int          CODE_W         = 32;
  localparam int          LEN_W          = 6;
  localparam logic [LEN_W-1:0] CODE_LEN_LIMIT =
    LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

  // pending bits plus the longest code
  localparam int PEND_W = 7;
  localparam int ACC_W  = PEND_W + CODE_W;

  // one table entry: masked code word and its length
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hte_entry_t;

  // clamp the length and drop code bits above it
  function automatic hte_entry_t hte_clamp_entry(input logic [CODE_W-1:0] word,
                                                 input logic [LEN_W-1:0]  len);
    hte_entry_t        e;
    logic [LEN_W-1:0]  l;
    logic [CODE_W-1:0] mask;
    l    = (len > CODE_LEN_LIMIT) ? CODE_LEN_LIMIT : len;
    mask = (l >= LEN_W'(CODE_W)) ? '1 : ~({CODE_W{1'b1}} << l);
    e.code = word & mask;
    e.len  = l;
    return e;
  endfunction

endpackage

>>> rtl/core/hte_table.sv
// ----------------------------------------------------------------------------
// hte_table: code table memory
// Synchronous-read memory of code entries plus a valid bit per entry,
// so unloaded symbols read as zero length right after reset.
// ----------------------------------------------------------------------------
module hte_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int IDX_W        = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic                in_range,
  input  logic [IDX_W-1:0]    addr,
  input  hte_pkg::hte_entry_t wr_entry,
  output hte_pkg::hte_entry_t rd_entry,
  output logic                rd_hit
);
  import hte_pkg::*;

  hte_entry_t              mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded;

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[addr];
    end
  end

  // valid bits and registered hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en && in_range) begin
        loaded[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= in_range && loaded[addr];
      end
    end
  end

endmodule

>>> rtl/core/hte_pack.sv
// ----------------------------------------------------------------------------
// hte_pack: bit accumulator and byte drain
// Merges a looked-up code into the pending bits, and shifts the completed
// bytes (or the finish pair) out one per cycle while the output is ready, through a registered drain.
// ----------------------------------------------------------------------------
module hte_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_finish,
  output logic                in_ready,
  input  hte_pkg::hte_entry_t entry,
  input  logic                entry_hit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import hte_pkg::*;

  logic                s1_valid;
  logic                s1_finish;
  logic [PEND_W-1:0]   pending_bits;
  logic [2:0]          pending_count;
  logic [31:0]         drain_word;
  logic [2:0]          drain_count;

  logic [LEN_W-1:0]    eff_len;
  logic [CODE_W-1:0]   eff_code;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    full;
  logic [5:0]          total;
  logic [2:0]          rem;
  logic [2:0]          nbytes;
  logic [5:0]          shamt;
  logic [31:0]         enc_word;
  logic [7:0]          fin_byte;
  logic [31:0]         s1_word;
  logic [2:0]          s1_bytes;
  logic [PEND_W-1:0]   pending_bits_next;
  logic [2:0]          pending_count_next;
  logic                drain_free;
  logic                s1_go;

  // merge the code into the accumulator and split off whole bytes
  always_comb begin
    eff_len  = entry_hit ? entry.len  : '0;
    eff_code = entry_hit ? entry.code : '0;
    acc      = (ACC_W'(pending_bits) << eff_len) | ACC_W'(eff_code);
    total    = 6'(pending_count) + eff_len;
    rem      = total[2:0];
    nbytes   = total[5:3];
    full     = acc >> rem;
    shamt    = 6'd32 - {nbytes, 3'b000};
    enc_word = full[31:0] << shamt;
    fin_byte = (pending_count != 3'd0)
             ? 8'({1'b0, pending_bits} << (4'd8 - 4'(pending_count)))
             : 8'd0;
    if (s1_finish) begin
      s1_word            = {fin_byte, 5'd0, pending_count, 16'd0};
      s1_bytes           = 3'd2;
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      s1_word            = enc_word;
      s1_bytes           = nbytes;
      pending_bits_next  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
      pending_count_next = rem;
    end
  end

  // stage advances when it has no bytes or its bytes fit in the drain
  assign drain_free = (drain_count == 3'd0) || (drain_count == 3'd1 && out_ready);
  assign s1_go      = s1_valid && ((s1_bytes == 3'd0) || drain_free);
  assign in_ready   = !s1_valid || s1_go;

  // lookup stage control and pending bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_finish     <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (in_ready) begin
        s1_valid  <= in_valid;
        s1_finish <= in_finish;
      end
      if (s1_go) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

  // byte drain, top byte first
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_count <= '0;
    end else if (s1_go && s1_bytes != 3'd0) begin
      drain_count <= s1_bytes;
    end else if (out_valid && out_ready) begin
      drain_count <= drain_count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_bytes != 3'd0) begin
      drain_word <= s1_word;
    end else if (out_valid && out_ready) begin
      drain_word <= {drain_word[23:0], 8'd0};
    end
  end

  assign out_valid = (drain_count != 3'd0);
  assign out_byte  = drain_word[31:24];
  assign out_last  = (drain_count == 3'd1);

endmodule

>>> rtl/core/huffman_table_encode_pack.sv
// ----------------------------------------------------------------------------
// huffman_table_encode_pack: table-driven variable-length encoder and packer
// Loads code entries into a table memory, encodes byte symbols through it and
// packs the code bits MSB first into bytes, with a padded finish trailer.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                                    tuser / tlast
//  s_axis   in         [7:0] symbol, [39:8] code_word,          tuser[1:0]
//                      [45:40] code_length                      req_type
//  m_axis   out        [7:0] out_byte                           tlast = last
//
//  a request is taken every cycle while the drain keeps up; an encode emits
//  0 to 4 bytes and a finish emits 2, and every byte passes through
//  the single-byte output drain
//  table reads are registered alongside the lookup stage; bytes leave from the registered drain
//  rst clears the valid bits of the table and the pending bits
//  output stalls back up into s_axis_tready without losing requests
// ----------------------------------------------------------------------------
module huffman_table_encode_pack #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol, code_word, code_length, zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast
);
  import hte_pkg::*;

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic             accept;
  logic [7:0]       symbol;
  logic [CODE_W-1:0] code_word;
  logic [LEN_W-1:0] code_length;
  req_type_t        req;
  logic             is_load;
  logic             is_encode;
  logic             is_finish;
  logic             in_range;
  hte_entry_t       wr_entry;
  hte_entry_t       rd_entry;
  logic             rd_hit;

  // unpack the request
  assign symbol      = s_axis_tdata[7:0];
  assign code_word   = s_axis_tdata[39:8];
  assign code_length = s_axis_tdata[45:40];
  assign req         = req_type_t'(s_axis_tuser);
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign in_range    = (9'(symbol) < 9'(SYMBOL_COUNT));
  assign wr_entry    = hte_clamp_entry(code_word, code_length);

  // decode the request kind, unused codes do nothing
  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_finish = 1'b0;
    case (req)
      REQ_LOAD:   is_load   = 1'b1;
      REQ_ENCODE: is_encode = 1'b1;
      REQ_FINISH: is_finish = 1'b1;
      default: ;
    endcase
  end

  // table writes land at the accept edge, so a later encode sees them
  hte_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && is_load),
    .rd_en    (accept && is_encode),
    .in_range (in_range),
    .addr     (symbol[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .rd_hit   (rd_hit)
  );

  // accumulate and drain
  hte_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid && (is_encode || is_finish)),
    .in_finish (is_finish),
    .in_ready  (s_axis_tready),
    .entry     (rd_entry),
    .entry_hit (rd_hit),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> rtl/core/hte_checker.sv
// ----------------------------------------------------------------------------
// hte_checker: port-level checks for the encoder and packer
// Watches output holding, byte bursts, reset and idle readiness.
// ----------------------------------------------------------------------------
module hte_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output byte changed while stalled");

  // bytes of one request leave without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a byte burst");

  // reset empties the drain
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // an empty drain never blocks requests
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind huffman_table_encode_pack hte_checker u_hte_checker (.*);
